>>> rtl/top_n_usage_tracker_macros.svh
// assertion macros for the top-n usage tracker
`ifndef TOP_N_USAGE_TRACKER_MACROS_SVH
`define TOP_N_USAGE_TRACKER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define TNU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tracker check failed");
// next-cycle implication, checked outside reset
`define TNU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tracker check failed");
`else
`define TNU_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TNU_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/tnu_pkg.sv
package tnu_pkg;

    // parameter defaults
    localparam int TOP_SLOTS_DEF  = 8;
    localparam int LIST_KINDS_DEF = 3;
    localparam int ID_BITS_DEF    = 24;

    // fixed field widths
    localparam int ENTITY_W = 24;
    localparam int PKT_W    = 32;
    localparam int BYTE_W   = 40;
    localparam int KEY_W    = 40;
    localparam int KIND_W   = 2;
    localparam int RANK_W   = 3;

    // request function codes
    localparam logic FUNC_UPDATE = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    // per-cell operation
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_TAKE_UP
    } t_cell_op;

    // cell status toward the list control
    typedef struct packed {
        logic valid;
        logic hit;
        logic below;
    } t_cell_stat;

    // tracker control states
    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } t_state;

endpackage

>>> rtl/tnu_cell.sv
module tnu_cell
    import tnu_pkg::*;
#(
    parameter int ID_BITS = ID_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cell_op            i_op,
    input  logic                i_sort_bytes,
    input  logic [ID_BITS-1:0]  i_new_id,
    input  logic [PKT_W-1:0]    i_new_pkts,
    input  logic [BYTE_W-1:0]   i_new_bytes,
    input  logic [KEY_W-1:0]    i_new_key,
    input  logic                i_up_valid,
    input  logic [ID_BITS-1:0]  i_up_id,
    input  logic [PKT_W-1:0]    i_up_pkts,
    input  logic [BYTE_W-1:0]   i_up_bytes,
    output logic [ID_BITS-1:0]  o_id,
    output logic [PKT_W-1:0]    o_pkts,
    output logic [BYTE_W-1:0]   o_bytes,
    output t_cell_stat          o_stat
);

    logic               r_valid;
    logic [ID_BITS-1:0] r_id;
    logic [PKT_W-1:0]   r_pkts;
    logic [BYTE_W-1:0]  r_bytes;
    logic [KEY_W-1:0]   key;

    // slot occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            unique case (i_op)
                CELL_LOAD:    r_valid <= 1'b1;
                CELL_TAKE_UP: r_valid <= i_up_valid;
                default:      r_valid <= r_valid;
            endcase
        end
    end

    // slot contents
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            CELL_LOAD: begin
                r_id    <= i_new_id;
                r_pkts  <= i_new_pkts;
                r_bytes <= i_new_bytes;
            end
            CELL_TAKE_UP: begin
                r_id    <= i_up_id;
                r_pkts  <= i_up_pkts;
                r_bytes <= i_up_bytes;
            end
            default: begin
                r_id    <= r_id;
                r_pkts  <= r_pkts;
                r_bytes <= r_bytes;
            end
        endcase
    end

    // ranking key and compares against the incoming request
    assign key          = i_sort_bytes ? r_bytes : KEY_W'(r_pkts);
    assign o_stat.valid = r_valid;
    assign o_stat.hit   = r_valid && (r_id == i_new_id);
    assign o_stat.below = r_valid && (key < i_new_key);

    assign o_id    = r_id;
    assign o_pkts  = r_pkts;
    assign o_bytes = r_bytes;

endmodule

>>> rtl/tnu_list.sv
module tnu_list
    import tnu_pkg::*;
#(
    parameter int TOP_SLOTS = TOP_SLOTS_DEF,
    parameter int ID_BITS   = ID_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_upd,
    input  logic                i_shift,
    input  logic                i_sort_bytes,
    input  logic [ID_BITS-1:0]  i_new_id,
    input  logic [PKT_W-1:0]    i_new_pkts,
    input  logic [BYTE_W-1:0]   i_new_bytes,
    input  logic [KEY_W-1:0]    i_new_key,
    output logic                o_head_valid,
    output logic [ID_BITS-1:0]  o_head_id,
    output logic [PKT_W-1:0]    o_head_pkts,
    output logic [BYTE_W-1:0]   o_head_bytes
);

    t_cell_stat         stat   [TOP_SLOTS];
    logic [ID_BITS-1:0] c_id   [TOP_SLOTS];
    logic [PKT_W-1:0]   c_pkts [TOP_SLOTS];
    logic [BYTE_W-1:0]  c_bytes[TOP_SLOTS];
    logic [ID_BITS-1:0] up_id  [TOP_SLOTS];
    logic [PKT_W-1:0]   up_pkts[TOP_SLOTS];
    logic [BYTE_W-1:0]  up_bytes[TOP_SLOTS];
    logic               up_valid[TOP_SLOTS];
    t_cell_op           op     [TOP_SLOTS];

    logic [TOP_SLOTS-1:0] hit;
    logic [TOP_SLOTS-1:0] free_run;
    logic [TOP_SLOTS-1:0] start;
    logic [TOP_SLOTS-1:0] act;
    logic [TOP_SLOTS-1:0] pass;
    logic                 found;

    // upper neighbor of each cell, empty above the top cell
    always_comb begin
        for (int i = 0; i < TOP_SLOTS; i++) begin
            if (i == TOP_SLOTS - 1) begin
                up_valid[i] = 1'b0;
                up_id[i]    = '0;
                up_pkts[i]  = '0;
                up_bytes[i] = '0;
            end else begin
                up_valid[i] = stat[i+1].valid;
                up_id[i]    = c_id[i+1];
                up_pkts[i]  = c_pkts[i+1];
                up_bytes[i] = c_bytes[i+1];
            end
        end
    end

    // entry point: hit slot, top of the free run, or evict slot 0
    always_comb begin
        for (int i = 0; i < TOP_SLOTS; i++) begin
            hit[i] = stat[i].hit;
        end
        found = |hit;
        free_run[0] = !stat[0].valid;
        for (int i = 1; i < TOP_SLOTS; i++) begin
            free_run[i] = free_run[i-1] && !stat[i].valid;
        end
        for (int i = 0; i < TOP_SLOTS; i++) begin
            if (found) begin
                start[i] = hit[i];
            end else if (!stat[0].valid) begin
                if (i == TOP_SLOTS - 1) begin
                    start[i] = free_run[i];
                end else begin
                    start[i] = free_run[i] && stat[i+1].valid;
                end
            end else begin
                start[i] = (i == 0) && stat[0].below;
            end
        end
    end

    // bubble path: the entry passes upward while the next key is smaller
    always_comb begin
        act[0] = start[0];
        for (int i = 1; i < TOP_SLOTS; i++) begin
            act[i] = start[i] || (act[i-1] && stat[i].below);
        end
        for (int i = 0; i < TOP_SLOTS; i++) begin
            if (i == TOP_SLOTS - 1) begin
                pass[i] = 1'b0;
            end else begin
                pass[i] = act[i] && stat[i+1].below;
            end
        end
    end

    // per-cell operation
    always_comb begin
        for (int i = 0; i < TOP_SLOTS; i++) begin
            if (i_shift) begin
                op[i] = CELL_TAKE_UP;
            end else if (i_upd && act[i]) begin
                op[i] = pass[i] ? CELL_TAKE_UP : CELL_LOAD;
            end else begin
                op[i] = CELL_HOLD;
            end
        end
    end

    // row of slot cells
    for (genvar g = 0; g < TOP_SLOTS; g++) begin : g_cell
        tnu_cell #(
            .ID_BITS (ID_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_op         (op[g]),
            .i_sort_bytes (i_sort_bytes),
            .i_new_id     (i_new_id),
            .i_new_pkts   (i_new_pkts),
            .i_new_bytes  (i_new_bytes),
            .i_new_key    (i_new_key),
            .i_up_valid   (up_valid[g]),
            .i_up_id      (up_id[g]),
            .i_up_pkts    (up_pkts[g]),
            .i_up_bytes   (up_bytes[g]),
            .o_id         (c_id[g]),
            .o_pkts       (c_pkts[g]),
            .o_bytes      (c_bytes[g]),
            .o_stat       (stat[g])
        );
    end

    // slot 0 feeds the dump
    assign o_head_valid = stat[0].valid;
    assign o_head_id    = c_id[0];
    assign o_head_pkts  = c_pkts[0];
    assign o_head_bytes = c_bytes[0];

endmodule

>>> rtl/top_n_usage_tracker.sv
// update: applied in the cycle it is accepted, one update per cycle while idle
// tick: dump entered via the state register, one slot per cycle while the output does not
// stall, LIST_KINDS*TOP_SLOTS results in all; the dump shifts each list down its row of
// cells toward slot 0; input is stalled for the dump and longer while the output stalls
// reset (synchronous, active low) empties all slots, clears the sort mode
// and the output valid; no clearing pass
`include "top_n_usage_tracker_macros.svh"

module top_n_usage_tracker
    import tnu_pkg::*;
#(
    parameter int TOP_SLOTS  = TOP_SLOTS_DEF,
    parameter int LIST_KINDS = LIST_KINDS_DEF,
    parameter int ID_BITS    = ID_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_func,
    input  logic [KIND_W-1:0]   i_list_kind,
    input  logic [ENTITY_W-1:0] i_entity_id,
    input  logic [PKT_W-1:0]    i_packet_count,
    input  logic [BYTE_W-1:0]   i_byte_count,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [KIND_W-1:0]   o_out_kind,
    output logic [RANK_W-1:0]   o_rank_slot,
    output logic                o_slot_used,
    output logic [ENTITY_W-1:0] o_out_entity,
    output logic [PKT_W-1:0]    o_out_packets,
    output logic [BYTE_W-1:0]   o_out_bytes,
    output logic                o_last_of_dump
);

    localparam int SLOT_CW = $clog2(TOP_SLOTS);
    localparam int KIND_CW = (LIST_KINDS > 1) ? $clog2(LIST_KINDS) : 1;

    t_state               r_state;
    t_state               n_state;
    logic                 r_sort_bytes;
    logic [SLOT_CW-1:0]   r_slot_cnt;
    logic [KIND_CW-1:0]   r_kind_cnt;

    logic                 r_out_valid;
    logic [KIND_W-1:0]    r_out_kind;
    logic [RANK_W-1:0]    r_out_slot;
    logic                 r_out_used;
    logic [ENTITY_W-1:0]  r_out_entity;
    logic [PKT_W-1:0]     r_out_pkts;
    logic [BYTE_W-1:0]    r_out_bytes;
    logic                 r_out_last;

    logic                 in_accept;
    logic                 out_adv;
    logic                 dump_step;
    logic                 last_slot;
    logic                 last_kind;
    logic [ID_BITS-1:0]   new_id;
    logic [KEY_W-1:0]     new_key;

    logic                 h_valid[LIST_KINDS];
    logic [ID_BITS-1:0]   h_id   [LIST_KINDS];
    logic [PKT_W-1:0]     h_pkts [LIST_KINDS];
    logic [BYTE_W-1:0]    h_bytes[LIST_KINDS];

    // handshakes
    assign in_accept = i_in_valid && !o_in_stall;
    assign out_adv   = !r_out_valid || !i_out_stall;
    assign last_slot = (r_slot_cnt == SLOT_CW'(TOP_SLOTS - 1));
    assign last_kind = (r_kind_cnt == KIND_CW'(LIST_KINDS - 1));

    // request fields as stored in the cells
    assign new_id  = ID_BITS'(i_entity_id);
    assign new_key = r_sort_bytes ? i_byte_count : KEY_W'(i_packet_count);

    // sort mode register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sort_bytes <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_sort_bytes <= i_cfg_data;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept && (i_func == FUNC_TICK)) begin
                    n_state = ST_DUMP;
                end
            end
            ST_DUMP: begin
                if (out_adv && last_slot && last_kind) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall = 1'b0;
        dump_step  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                dump_step  = 1'b0;
            end
            ST_DUMP: begin
                o_in_stall = 1'b1;
                dump_step  = out_adv;
            end
            default: begin
                o_in_stall = 1'b1;
                dump_step  = 1'b0;
            end
        endcase
    end

    // state and dump position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_slot_cnt <= '0;
            r_kind_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (dump_step) begin
                if (last_slot) begin
                    r_slot_cnt <= '0;
                    r_kind_cnt <= last_kind ? '0 : r_kind_cnt + 1'b1;
                end else begin
                    r_slot_cnt <= r_slot_cnt + 1'b1;
                end
            end
        end
    end

    // one row of cells per list
    for (genvar k = 0; k < LIST_KINDS; k++) begin : g_list
        tnu_list #(
            .TOP_SLOTS (TOP_SLOTS),
            .ID_BITS   (ID_BITS)
        ) u_list (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_upd        (in_accept && (i_func == FUNC_UPDATE) &&
                           (i_list_kind == KIND_W'(k))),
            .i_shift      (dump_step && (r_kind_cnt == KIND_CW'(k))),
            .i_sort_bytes (r_sort_bytes),
            .i_new_id     (new_id),
            .i_new_pkts   (i_packet_count),
            .i_new_bytes  (i_byte_count),
            .i_new_key    (new_key),
            .o_head_valid (h_valid[k]),
            .o_head_id    (h_id[k]),
            .o_head_pkts  (h_pkts[k]),
            .o_head_bytes (h_bytes[k])
        );
    end

    // output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= dump_step;
        end
    end

    // output register payload, empty slots read as zero
    always_ff @(posedge i_clk) begin
        if (dump_step) begin
            r_out_kind   <= KIND_W'(r_kind_cnt);
            r_out_slot   <= RANK_W'(r_slot_cnt);
            r_out_used   <= h_valid[r_kind_cnt];
            r_out_entity <= h_valid[r_kind_cnt] ? ENTITY_W'(h_id[r_kind_cnt]) : '0;
            r_out_pkts   <= h_valid[r_kind_cnt] ? h_pkts[r_kind_cnt] : '0;
            r_out_bytes  <= h_valid[r_kind_cnt] ? h_bytes[r_kind_cnt] : '0;
            r_out_last   <= last_slot && last_kind;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_kind     = r_out_kind;
    assign o_rank_slot    = r_out_slot;
    assign o_slot_used    = r_out_used;
    assign o_out_entity   = r_out_entity;
    assign o_out_packets  = r_out_pkts;
    assign o_out_bytes    = r_out_bytes;
    assign o_last_of_dump = r_out_last;

    // checks
    `TNU_ASSERT_NXT(a_tick_starts_dump, i_clk, i_rst_n, in_accept && (i_func == FUNC_TICK), r_state == ST_DUMP)
    `TNU_ASSERT_NXT(a_last_ends_dump, i_clk, i_rst_n, dump_step && last_slot && last_kind, r_state == ST_IDLE)
    `TNU_ASSERT_IMP(a_idle_counters_home, i_clk, i_rst_n, r_state == ST_IDLE, (r_slot_cnt == '0) && (r_kind_cnt == '0))

endmodule
